// ----- rtl/core/xed_pkg.sv -----
`timescale 1ns / 1ps

package xed_pkg;

    // Characters the decoder acts on
    localparam logic [7:0] CH_AMP  = 8'h26;  // '&'
    localparam logic [7:0] CH_SEMI = 8'h3B;  // ';'
    localparam logic [7:0] CH_LT   = 8'h3C;  // '<'
    localparam logic [7:0] CH_GT   = 8'h3E;  // '>'
    localparam logic [7:0] CH_QUOT = 8'h22;  // '"'
    localparam logic [7:0] CH_APOS = 8'h27;  // '\''

    // Letters used in the predefined entity names
    localparam logic [7:0] CH_A = 8'h61;
    localparam logic [7:0] CH_G = 8'h67;
    localparam logic [7:0] CH_L = 8'h6C;
    localparam logic [7:0] CH_M = 8'h6D;
    localparam logic [7:0] CH_O = 8'h6F;
    localparam logic [7:0] CH_P = 8'h70;
    localparam logic [7:0] CH_Q = 8'h71;
    localparam logic [7:0] CH_S = 8'h73;
    localparam logic [7:0] CH_T = 8'h74;
    localparam logic [7:0] CH_U = 8'h75;

    // Source of an emitted byte
    typedef enum logic [2:0] {
        EMIT_BYTE,   // captured input byte
        EMIT_HELD,   // held name byte at the read cursor
        EMIT_REPL,   // replacement character of a matched entity
        EMIT_AMP,    // literal '&'
        EMIT_SEMI    // literal ';'
    } t_emit_sel;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic      load;      // capture the accepted input transaction
        logic      emit;      // push a byte into the pending slot
        t_emit_sel emit_sel;
        logic      wr_held;   // write held[cnt]
        logic      wr_sel;    // 0: input byte, 1: held[idx]
        logic      cnt_inc;
        logic      cnt_clr;
        logic      ref_set;
        logic      ref_clr;
        logic      idx_inc;
        logic      idx_clr;
        logic      finish;    // close the step: pending byte goes out as last
    } t_dp_cmd;

    // Status from the datapath to the controller
    typedef struct packed {
        logic in_ref;
        logic end_flag;
        logic byte_amp;
        logic byte_semi;
        logic cnt_full;
        logic idx_at_cnt;
        logic idx_last;
        logic held_amp;
        logic match;
        logic pend_v;
        logic can_emit;
    } t_dp_status;

    typedef struct packed {
        logic       hit;
        logic [7:0] repl;
    } t_ent_hit;

    // Predefined entity lookup on the first four held bytes and the name length
    function automatic t_ent_hit ent_lookup(
        input logic [7:0] b0,
        input logic [7:0] b1,
        input logic [7:0] b2,
        input logic [7:0] b3,
        input logic [3:0] len
    );
        t_ent_hit r;
        r.hit  = 1'b0;
        r.repl = CH_AMP;
        if (len == 4'd3 && b0 == CH_A && b1 == CH_M && b2 == CH_P) begin
            r.hit  = 1'b1;
            r.repl = CH_AMP;
        end else if (len == 4'd2 && b0 == CH_L && b1 == CH_T) begin
            r.hit  = 1'b1;
            r.repl = CH_LT;
        end else if (len == 4'd2 && b0 == CH_G && b1 == CH_T) begin
            r.hit  = 1'b1;
            r.repl = CH_GT;
        end else if (len == 4'd4 && b0 == CH_Q && b1 == CH_U && b2 == CH_O && b3 == CH_T) begin
            r.hit  = 1'b1;
            r.repl = CH_QUOT;
        end else if (len == 4'd4 && b0 == CH_A && b1 == CH_P && b2 == CH_O && b3 == CH_S) begin
            r.hit  = 1'b1;
            r.repl = CH_APOS;
        end
        return r;
    endfunction

endpackage

// ----- rtl/core/xed_if.sv -----
`timescale 1ns / 1ps

// Input text channel
interface xed_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] text_byte;
    logic       end_of_text;

    modport source (output valid, output text_byte, output end_of_text, input ready);
    modport sink   (input valid, input text_byte, input end_of_text, output ready);
endinterface

// Decoded byte channel
interface xed_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       run_last;
    logic       text_done;

    modport source (output valid, output out_byte, output run_last, output text_done,
                    input ready);
    modport sink   (input valid, input out_byte, input run_last, input text_done,
                    output ready);
endinterface

// ----- rtl/core/xml_entity_decoder_core.sv -----
`timescale 1ns / 1ps

// XML predefined entity decoder.
// i_text (sink) takes one text byte per transaction with an end_of_text flag.
// o_res (source) gives decoded bytes; run_last marks the final byte caused by
// an input transaction, text_done the final byte of a text. An input may
// cause no output at all (bytes held inside a reference).
// Bytes following '&' are held in a WINDOW-entry register file until ';'.
// Known names (amp, lt, gt, quot, apos) turn into one character, unknown ones
// come out verbatim with '&' and ';'. A full window or end of text releases
// '&' and the held bytes; after a full window they are replayed and may open
// a new reference, at end of text they come out verbatim. The controller
// steps one byte at a time through a single datapath and takes no new input
// until it is done with the last one.
// A plain byte or matched entity waits in the pending slot and goes to o_res
// when the transaction closes; other bytes wait in the pending slot until the
// next is made.
// Reset clears the controller, the reference state and the output register.
// A stalled receiver holds the output register; the controller waits until
// it can move its pending byte on, and takes no input meanwhile.
module xml_entity_decoder_core
    import xed_pkg::*;
#(
    parameter int WINDOW = 8
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    xed_in_if.sink     i_text,
    xed_out_if.source  o_res
);

    t_dp_cmd    cmd;
    t_dp_status status;

    xed_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_text.valid),
        .o_ready  (i_text.ready),
        .i_status (status),
        .o_cmd    (cmd)
    );

    xed_dp #(
        .WINDOW (WINDOW)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_text_byte   (i_text.text_byte),
        .i_end_of_text (i_text.end_of_text),
        .i_cmd         (cmd),
        .o_status      (status),
        .o_res         (o_res)
    );

endmodule

// ----- rtl/core/xed_dp.sv -----
`timescale 1ns / 1ps

module xed_dp
    import xed_pkg::*;
#(
    parameter int WINDOW = 8
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic [7:0]   i_text_byte,
    input  logic         i_end_of_text,
    input  t_dp_cmd      i_cmd,
    output t_dp_status   o_status,
    xed_out_if.source    o_res
);

    localparam int IW = $clog2(WINDOW);

    // Held name bytes, no reset
    logic [7:0]    r_held [WINDOW];
    logic [IW-1:0] r_cnt;
    logic [IW-1:0] r_idx;
    logic          r_in_ref;

    // Captured input transaction
    logic [7:0]    r_byte;
    logic          r_end;

    // One-deep pending slot, so the last byte of a step can be flagged
    logic          r_pend_v;
    logic [7:0]    r_pend;

    // Output register
    logic          r_out_v;
    logic [7:0]    r_out_byte;
    logic          r_out_last;
    logic          r_out_done;

    logic [7:0]    held_rd;
    logic [7:0]    emit_byte;
    logic [7:0]    wr_byte;
    logic          out_free;
    logic          push;
    t_ent_hit      ent;

    assign held_rd  = r_held[r_idx];
    assign out_free = !r_out_v || o_res.ready;
    assign push     = r_pend_v && (i_cmd.emit || i_cmd.finish);
    assign ent      = ent_lookup(r_held[0], r_held[1], r_held[2], r_held[3], 4'(r_cnt));
    assign wr_byte  = i_cmd.wr_sel ? held_rd : r_byte;

    // Byte selection for the pending slot
    always_comb begin
        case (i_cmd.emit_sel)
            EMIT_BYTE: emit_byte = r_byte;
            EMIT_HELD: emit_byte = held_rd;
            EMIT_REPL: emit_byte = ent.repl;
            EMIT_AMP:  emit_byte = CH_AMP;
            EMIT_SEMI: emit_byte = CH_SEMI;
            default:   emit_byte = CH_AMP;
        endcase
    end

    // Status towards the controller
    always_comb begin
        o_status.in_ref     = r_in_ref;
        o_status.end_flag   = r_end;
        o_status.byte_amp   = (r_byte == CH_AMP);
        o_status.byte_semi  = (r_byte == CH_SEMI);
        o_status.cnt_full   = (r_cnt == IW'(WINDOW - 1));
        o_status.idx_at_cnt = (r_idx == r_cnt);
        o_status.idx_last   = (r_idx == IW'(WINDOW - 1));
        o_status.held_amp   = (held_rd == CH_AMP);
        o_status.match      = ent.hit;
        o_status.pend_v     = r_pend_v;
        o_status.can_emit   = !r_pend_v || out_free;
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_ref <= 1'b0;
            r_cnt    <= '0;
            r_idx    <= '0;
            r_pend_v <= 1'b0;
            r_out_v  <= 1'b0;
        end else begin
            if (i_cmd.ref_set) begin
                r_in_ref <= 1'b1;
            end else if (i_cmd.ref_clr) begin
                r_in_ref <= 1'b0;
            end
            if (i_cmd.cnt_clr) begin
                r_cnt <= '0;
            end else if (i_cmd.cnt_inc) begin
                r_cnt <= r_cnt + 1'b1;
            end
            if (i_cmd.idx_clr) begin
                r_idx <= '0;
            end else if (i_cmd.idx_inc) begin
                r_idx <= r_idx + 1'b1;
            end
            if (i_cmd.emit) begin
                r_pend_v <= 1'b1;
            end else if (i_cmd.finish) begin
                r_pend_v <= 1'b0;
            end
            if (push) begin
                r_out_v <= 1'b1;
            end else if (o_res.ready) begin
                r_out_v <= 1'b0;
            end
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_byte <= i_text_byte;
            r_end  <= i_end_of_text;
        end
        if (i_cmd.wr_held) begin
            r_held[r_cnt] <= wr_byte;
        end
        if (i_cmd.emit) begin
            r_pend <= emit_byte;
        end
        if (push) begin
            r_out_byte <= r_pend;
            r_out_last <= i_cmd.finish;
            r_out_done <= i_cmd.finish && r_end;
        end
    end

    assign o_res.valid     = r_out_v;
    assign o_res.out_byte  = r_out_byte;
    assign o_res.run_last  = r_out_last;
    assign o_res.text_done = r_out_done;

endmodule

// ----- rtl/core/xed_ctrl.sv -----
`timescale 1ns / 1ps

module xed_ctrl
    import xed_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  t_dp_status  i_status,
    output t_dp_cmd     o_cmd
);

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_FEED   = 3'd1;
    localparam logic [2:0] S_REPLAY = 3'd2;
    localparam logic [2:0] S_VERB   = 3'd3;
    localparam logic [2:0] S_SEMI   = 3'd4;
    localparam logic [2:0] S_END    = 3'd5;
    localparam logic [2:0] S_FLUSH  = 3'd6;
    localparam logic [2:0] S_LAST   = 3'd7;

    logic [2:0] r_state;
    logic [2:0] n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state and datapath commands
    always_comb begin
        n_state  = r_state;
        o_ready  = 1'b0;
        o_cmd    = '0;
        o_cmd.emit_sel = EMIT_BYTE;
        case (r_state)
            S_IDLE: begin
                o_ready    = 1'b1;
                o_cmd.load = i_valid;
                if (i_valid) begin
                    n_state = S_FEED;
                end
            end
            // Top-level handling of the captured byte
            S_FEED: begin
                if (!i_status.in_ref) begin
                    if (i_status.byte_amp) begin
                        o_cmd.ref_set = 1'b1;
                        o_cmd.cnt_clr = 1'b1;
                        n_state       = S_END;
                    end else if (i_status.can_emit) begin
                        o_cmd.emit = 1'b1;
                        n_state    = S_END;
                    end
                end else if (i_status.byte_semi) begin
                    if (i_status.can_emit) begin
                        o_cmd.emit = 1'b1;
                        if (i_status.match) begin
                            o_cmd.emit_sel = EMIT_REPL;
                            o_cmd.ref_clr  = 1'b1;
                            o_cmd.cnt_clr  = 1'b1;
                            n_state        = S_END;
                        end else begin
                            o_cmd.emit_sel = EMIT_AMP;
                            o_cmd.idx_clr  = 1'b1;
                            n_state        = S_VERB;
                        end
                    end
                end else if (!i_status.cnt_full) begin
                    o_cmd.wr_held = 1'b1;
                    o_cmd.cnt_inc = 1'b1;
                    n_state       = S_END;
                end else if (i_status.can_emit) begin
                    // window full: store the byte as the last entry, then replay
                    o_cmd.wr_held  = 1'b1;
                    o_cmd.emit     = 1'b1;
                    o_cmd.emit_sel = EMIT_AMP;
                    o_cmd.ref_clr  = 1'b1;
                    o_cmd.cnt_clr  = 1'b1;
                    o_cmd.idx_clr  = 1'b1;
                    n_state        = S_REPLAY;
                end
            end
            // Replay held bytes through the decoder, compacting after a new '&'
            S_REPLAY: begin
                if (i_status.in_ref) begin
                    o_cmd.wr_held = 1'b1;
                    o_cmd.wr_sel  = 1'b1;
                    o_cmd.cnt_inc = 1'b1;
                    o_cmd.idx_inc = !i_status.idx_last;
                    if (i_status.idx_last) begin
                        n_state = S_END;
                    end
                end else if (i_status.held_amp) begin
                    o_cmd.ref_set = 1'b1;
                    o_cmd.cnt_clr = 1'b1;
                    o_cmd.idx_inc = !i_status.idx_last;
                    if (i_status.idx_last) begin
                        n_state = S_END;
                    end
                end else if (i_status.can_emit) begin
                    o_cmd.emit     = 1'b1;
                    o_cmd.emit_sel = EMIT_HELD;
                    o_cmd.idx_inc  = !i_status.idx_last;
                    if (i_status.idx_last) begin
                        n_state = S_END;
                    end
                end
            end
            // Unknown name: held bytes verbatim, then ';'
            S_VERB: begin
                if (i_status.idx_at_cnt) begin
                    n_state = S_SEMI;
                end else if (i_status.can_emit) begin
                    o_cmd.emit     = 1'b1;
                    o_cmd.emit_sel = EMIT_HELD;
                    o_cmd.idx_inc  = 1'b1;
                end
            end
            S_SEMI: begin
                if (i_status.can_emit) begin
                    o_cmd.emit     = 1'b1;
                    o_cmd.emit_sel = EMIT_SEMI;
                    o_cmd.ref_clr  = 1'b1;
                    o_cmd.cnt_clr  = 1'b1;
                    n_state        = S_END;
                end
            end
            // End of text with an open reference flushes it
            S_END: begin
                if (i_status.end_flag && i_status.in_ref) begin
                    if (i_status.can_emit) begin
                        o_cmd.emit     = 1'b1;
                        o_cmd.emit_sel = EMIT_AMP;
                        o_cmd.idx_clr  = 1'b1;
                        n_state        = S_FLUSH;
                    end
                end else begin
                    n_state = S_LAST;
                end
            end
            S_FLUSH: begin
                if (i_status.idx_at_cnt) begin
                    o_cmd.ref_clr = 1'b1;
                    o_cmd.cnt_clr = 1'b1;
                    n_state       = S_LAST;
                end else if (i_status.can_emit) begin
                    o_cmd.emit     = 1'b1;
                    o_cmd.emit_sel = EMIT_HELD;
                    o_cmd.idx_inc  = 1'b1;
                end
            end
            // Release the pending byte flagged as last of the transaction
            S_LAST: begin
                if (!i_status.pend_v || i_status.can_emit) begin
                    o_cmd.finish = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule
